### hdl/mecd_pkg.sv
package mecd_pkg;

	// Result kinds as carried on m_tuser
	localparam logic [2:0] KIND_DOT    = 3'd0;
	localparam logic [2:0] KIND_DASH   = 3'd1;
	localparam logic [2:0] KIND_GAP    = 3'd2;
	localparam logic [2:0] KIND_LETTER = 3'd3;
	localparam logic [2:0] KIND_ERROR  = 3'd4;

	// Modes as carried on s_tuser
	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_DASH   = 8'h2D;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
	localparam logic [7:0] CHAR_LO_A   = 8'h61;
	localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam int          NUM_LETTERS = 26;
	localparam logic [2:0]  TOKEN_MAX   = 3'd4;

	// Per letter {length, code}; code bit i is symbol i, 1 = dash
	localparam logic [6:0] MORSE_TAB [NUM_LETTERS] = '{
		{3'd2, 4'd2},  {3'd4, 4'd1},  {3'd4, 4'd5},  {3'd3, 4'd1},  {3'd1, 4'd0},
		{3'd4, 4'd4},  {3'd3, 4'd3},  {3'd4, 4'd0},  {3'd2, 4'd0},  {3'd4, 4'd14},
		{3'd3, 4'd5},  {3'd4, 4'd2},  {3'd2, 4'd3},  {3'd2, 4'd1},  {3'd3, 4'd7},
		{3'd4, 4'd6},  {3'd4, 4'd11}, {3'd3, 4'd2},  {3'd3, 4'd0},  {3'd1, 4'd1},
		{3'd3, 4'd4},  {3'd4, 4'd8},  {3'd3, 4'd6},  {3'd4, 4'd9},  {3'd4, 4'd13},
		{3'd4, 4'd3}
	};

	// One unit of work for the emitter: len symbols from code, then one
	// closing result of the given kind and letter.
	typedef struct packed {
		logic [3:0] code;
		logic [2:0] len;
		logic [2:0] kind;
		logic [7:0] letter;
	} job_t;

	// Returns {hit, letter} for a token
	function automatic logic [8:0] morse_lookup(input logic [2:0] len, input logic [3:0] code);
		logic [8:0] r;
		r = '0;
		for (int i = 0; i < NUM_LETTERS; i++) begin
			if (MORSE_TAB[i] == {len, code})
				r = {1'b1, CHAR_UP_A + 8'(i)};
		end
		return r;
	endfunction

endpackage

### hdl/mecd_front.sv
module mecd_front
	import mecd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic       func,
	input  logic [7:0] char_in,
	input  logic       end_of_text,
	output logic       push,
	output job_t       job
);

	logic [3:0] tok_code_q;
	logic [2:0] tok_len_q;
	logic       tok_ovf_q;

	logic [3:0] tok_code_n;
	logic [2:0] tok_len_n;
	logic       tok_ovf_n;
	logic [3:0] cl_code;
	logic [2:0] cl_len;
	logic       cl_ovf;
	logic       do_close;
	logic       want;
	logic [7:0] up;
	logic [4:0] idx;
	logic [6:0] ent;
	logic [8:0] hit;

	always_comb begin
		tok_code_n = tok_code_q;
		tok_len_n  = tok_len_q;
		tok_ovf_n  = tok_ovf_q;
		cl_code    = tok_code_q;
		cl_len     = tok_len_q;
		cl_ovf     = tok_ovf_q;
		do_close   = 1'b0;
		want       = 1'b0;
		job        = '0;
		up         = char_in;
		if (char_in >= CHAR_LO_A && char_in <= CHAR_LO_Z)
			up = char_in - CASE_OFFSET;
		idx = 5'(up - CHAR_UP_A);
		ent = MORSE_TAB[idx];

		if (func == FUNC_ENCODE) begin
			want = 1'b1;
			if (up >= CHAR_UP_A && up <= CHAR_UP_Z) begin
				job.code = ent[3:0];
				job.len  = ent[6:4];
				job.kind = KIND_GAP;
			end else if (up == CHAR_SPACE) begin
				job.kind = KIND_GAP;
			end else begin
				job.kind = KIND_ERROR;
			end
		end else if (char_in == CHAR_DOT || char_in == CHAR_DASH) begin
			// append a symbol, or mark overflow past four
			if (tok_len_q < TOKEN_MAX) begin
				if (char_in == CHAR_DASH)
					cl_code = tok_code_q | (4'd1 << tok_len_q[1:0]);
				cl_len = tok_len_q + 3'd1;
			end else begin
				cl_ovf = 1'b1;
			end
			tok_code_n = cl_code;
			tok_len_n  = cl_len;
			tok_ovf_n  = cl_ovf;
			do_close   = end_of_text;
		end else if (char_in == CHAR_SPACE) begin
			do_close = 1'b1;
		end else begin
			tok_code_n = '0;
			tok_len_n  = '0;
			tok_ovf_n  = 1'b0;
			want       = 1'b1;
			job.kind   = KIND_ERROR;
		end

		hit = morse_lookup(cl_len, cl_code);
		if (do_close) begin
			tok_code_n = '0;
			tok_len_n  = '0;
			tok_ovf_n  = 1'b0;
			if (cl_len != 3'd0 || cl_ovf) begin
				want = 1'b1;
				if (!cl_ovf && hit[8]) begin
					job.kind   = KIND_LETTER;
					job.letter = hit[7:0];
				end else begin
					job.kind = KIND_ERROR;
				end
			end
		end
		push = acc && want;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_code_q <= '0;
			tok_len_q  <= '0;
			tok_ovf_q  <= 1'b0;
		end else if (acc) begin
			tok_code_q <= tok_code_n;
			tok_len_q  <= tok_len_n;
			tok_ovf_q  <= tok_ovf_n;
		end
	end

endmodule

### hdl/mecd_queue.sv
module mecd_queue
	import mecd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t rd_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign valid  = (cnt_q != '0);
	assign rd_job = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= nxt(wr_ptr_q);
			if (pop)
				rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH)) else $error("queue count past depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("push into full queue");

endmodule

### hdl/mecd_back.sv
module mecd_back
	import mecd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  job_t       q_job,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [2:0] m_tuser,
	output logic       m_tlast
);

	logic       cur_valid_q;
	job_t       cur_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_letter_q;
	logic [2:0] out_kind_q;
	logic       out_last_q;

	logic       out_free;
	logic       emit;
	logic       fin;

	assign out_free = !out_valid_q || m_tready;
	assign emit     = cur_valid_q && out_free;
	assign fin      = (idx_q == cur_q.len);
	assign pop      = q_valid && (!cur_valid_q || (emit && fin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				if (fin)
					cur_valid_q <= 1'b0;
				else
					idx_q <= idx_q + 3'd1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_job;
		if (emit) begin
			if (fin) begin
				out_kind_q   <= cur_q.kind;
				out_letter_q <= cur_q.letter;
				out_last_q   <= 1'b1;
			end else begin
				out_kind_q   <= cur_q.code[idx_q[1:0]] ? KIND_DASH : KIND_DOT;
				out_letter_q <= '0;
				out_last_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_letter_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= cur_q.len) else $error("symbol index past job length");
	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> cur_q.len <= TOKEN_MAX) else $error("job longer than four symbols");
	a_close_kind: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_q.kind == KIND_GAP || cur_q.kind == KIND_LETTER ||
			cur_q.kind == KIND_ERROR)) else $error("bad closing kind in job");

endmodule

### hdl/morse_encode_decode_unit.sv
// Streaming Morse codec for the letters A to Z.
// Input channel (s_*): one ASCII byte per transfer on s_tdata, mode on s_tuser
// (0 encode, 1 decode), s_tlast marks the final character of a text.
// Output channel (m_*): one result per transfer; m_tuser is the kind (dot, dash,
// gap, letter, error), m_tdata the decoded letter or zero, m_tlast set on the
// last result caused by an input.
// Encode: a letter (either case) gives its symbols then a gap, a space one gap,
// anything else one error. Decode: dots and dashes build a token of up to four
// symbols; a space or s_tlast closes it into a letter or an error.
// Path: a job passes the job queue and the current-job register; each of its
// results is registered at the output. An input gives 1 to 5 results (a letter
// of four symbols being the longest); inputs that give no result cost nothing
// on the output side. The result emitter, one result per cycle while m_tready
// does not stall it, sets the rate. The front takes one input per cycle while
// the job queue has room, so input and output stall independently: a stalled
// m_tready holds the output register, fills the queue, and then drops s_tready.
// Reset clears the decode token, the queue and the output register.
module morse_encode_decode_unit
	import mecd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tuser,   // [0] func
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] letter
	output logic [2:0] m_tuser,   // [2:0] kind
	output logic       m_tlast    // last
);

	logic q_full;
	logic q_valid;
	logic q_push;
	logic q_pop;
	logic acc;
	job_t wr_job;
	job_t rd_job;

	// accept whenever the queue can take a job
	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;

	mecd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.func        (s_tuser),
		.char_in     (s_tdata),
		.end_of_text (s_tlast),
		.push        (q_push),
		.job         (wr_job)
	);

	mecd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rd_job (rd_job)
	);

	mecd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_job    (rd_job),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
